// ===== sv/itvd_pkg.sv =====
// Shared types, character codes, status codes and field helpers for the timestamp checker.
package itvd_pkg;

  // Stored key: the first 25 characters of a valid line, zero past its length.
  localparam int KEY_BYTES = 25;
  typedef logic [KEY_BYTES-1:0][7:0] key_t;

  typedef logic [3:0] status_t;

  localparam status_t ST_NEW    = 4'd0;
  localparam status_t ST_DUP    = 4'd1;
  localparam status_t ST_BLANK  = 4'd2;
  localparam status_t ST_LENGTH = 4'd3;
  localparam status_t ST_STRUCT = 4'd4;
  localparam status_t ST_MONTH  = 4'd5;
  localparam status_t ST_DAY    = 4'd6;
  localparam status_t ST_HOUR   = 4'd7;
  localparam status_t ST_MINUTE = 4'd8;
  localparam status_t ST_SECOND = 4'd9;
  localparam status_t ST_ZONE   = 4'd10;
  localparam status_t ST_ZHOUR  = 4'd11;
  localparam status_t ST_ZMIN   = 4'd12;
  localparam status_t ST_FULL   = 4'd13;

  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam int LEN_ZULU   = 20;
  localparam int LEN_OFFSET = 25;

  // Space, tab, LF, VT, FF and CR count as whitespace.
  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Value of a two-character number under C atoi rules, range -9 to 99.
  function automatic logic signed [7:0] two_val(logic [7:0] a, logic [7:0] b);
    logic [7:0] da;
    logic [7:0] db;
    logic [7:0] v;
    da = a - CH_ZERO;
    db = b - CH_ZERO;
    v  = 8'd0;
    if (is_digit(a)) begin
      v = is_digit(b) ? 8'(da * 8'd10 + db) : da;
    end else if (is_blank(a) || (a == CH_PLUS)) begin
      v = is_digit(b) ? db : 8'd0;
    end else if (a == CH_DASH) begin
      v = is_digit(b) ? 8'(8'd0 - db) : 8'd0;
    end
    return $signed(v);
  endfunction

  function automatic logic out_of(logic [7:0] a, logic [7:0] b,
                                  logic signed [7:0] lo, logic signed [7:0] hi);
    logic signed [7:0] v;
    v = two_val(a, b);
    return (v < lo) || (v > hi);
  endfunction

endpackage

// ===== sv/itvd_fmt_check.sv =====
// Field checker: validates a buffered line of 20 or 25 characters field by field.
module itvd_fmt_check (
  input  itvd_pkg::key_t    line_bytes,
  input  logic              is_zulu,
  output itvd_pkg::status_t status
);
  import itvd_pkg::*;

  // Fields are checked left to right; the first failure sets the status.
  always_comb begin
    if (line_bytes[4] != CH_DASH) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[5], line_bytes[6], 8'sd1, 8'sd12)) begin
      status = ST_MONTH;
    end else if (line_bytes[7] != CH_DASH) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[8], line_bytes[9], 8'sd1, 8'sd31)) begin
      status = ST_DAY;
    end else if (line_bytes[10] != CH_T) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[11], line_bytes[12], 8'sd0, 8'sd23)) begin
      status = ST_HOUR;
    end else if (line_bytes[13] != CH_COLON) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[14], line_bytes[15], 8'sd0, 8'sd59)) begin
      status = ST_MINUTE;
    end else if (line_bytes[16] != CH_COLON) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[17], line_bytes[18], 8'sd0, 8'sd59)) begin
      status = ST_SECOND;
    end else if (is_zulu) begin
      status = (line_bytes[19] == CH_Z) ? ST_NEW : ST_ZONE;
    end else if ((line_bytes[19] != CH_PLUS) && (line_bytes[19] != CH_DASH)) begin
      status = ST_ZONE;
    end else if (out_of(line_bytes[20], line_bytes[21], 8'sd0, 8'sd23)) begin
      status = ST_ZHOUR;
    end else if (line_bytes[22] != CH_COLON) begin
      status = ST_STRUCT;
    end else if (out_of(line_bytes[23], line_bytes[24], 8'sd0, 8'sd59)) begin
      status = ST_ZMIN;
    end else begin
      status = ST_NEW;
    end
  end

endmodule

// ===== sv/iso8601_timestamp_validate_dedup_core.sv =====
// Top level: line buffer, format check, and table of seen timestamps in a synchronous memory.
// A line end moves from the check state through a read state and a compare state per stored
// entry compared to the done state, which loads its word into the output register.
// Throughput: one byte per cycle inside a line; a line end blocks input until its word is
// loaded into the output register, which waits while the previous word is still untaken.
// Duplicate search walks the stored entries one at a time through the memory read port.
// Reset (rst_n, synchronous) empties the line buffer and the table fill count; memory is not
// cleared, since entries past the fill count are never read.
module iso8601_timestamp_validate_dedup_core #(
  parameter int TABLE_ENTRIES     = 256,
  parameter int LINE_BUFFER_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_line,
  output logic              out_valid,
  input  logic              out_ready,
  output itvd_pkg::status_t out_status,
  output logic [7:0]        out_entry_index
);
  import itvd_pkg::*;

  localparam int PW = $clog2(LINE_BUFFER_BYTES + 1);
  localparam int BW = $clog2(LINE_BUFFER_BYTES);
  localparam int UW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_CMP, S_DONE} state_t;

  state_t          st_r;
  logic [7:0]      line_r [LINE_BUFFER_BYTES];
  logic [PW-1:0]   pos_r;
  logic [PW-1:0]   trim_r;
  logic            ovf_r;
  logic            ended_r;
  logic [UW-1:0]   used_r;
  logic [UW-1:0]   idx_r;
  status_t         res_status_r;
  logic [UW-1:0]   res_slot_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [7:0]      out_index_r;

  key_t            mem [TABLE_ENTRIES];
  key_t            rd_data;
  logic [AW-1:0]   rd_addr;
  logic            mem_we;
  key_t            raw;
  key_t            key;
  status_t         fmt_status;
  logic            in_acc;
  logic            last_slot;
  logic            no_match;
  logic            out_load;

  assign in_ready  = (st_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry_index = out_index_r;
  assign out_load  = (st_r == S_DONE) && (!out_valid_r || out_ready);

  // Raw line head for the checker, and the stored key zeroed past the trimmed length.
  always_comb begin
    for (int i = 0; i < KEY_BYTES; i++) begin
      raw[i] = line_r[i];
      key[i] = (i < int'(trim_r)) ? line_r[i] : 8'd0;
    end
  end

  itvd_fmt_check u_chk (
    .line_bytes (raw),
    .is_zulu    (trim_r == PW'(LEN_ZULU)),
    .status     (fmt_status)
  );

  assign rd_addr   = idx_r[AW-1:0];
  assign last_slot = (UW'(idx_r + 1'b1) == used_r);
  // A line with no match inserts, if the table has room, either straight from the check or after the last compare.
  assign no_match  = ((st_r == S_CHECK) && !ovf_r && (trim_r != '0) &&
                      ((trim_r == PW'(LEN_ZULU)) || (trim_r == PW'(LEN_OFFSET))) &&
                      (fmt_status == ST_NEW) && (used_r == '0)) ||
                     ((st_r == S_CMP) && (rd_data != key) && last_slot);
  assign mem_we    = no_match && (used_r < UW'(TABLE_ENTRIES));

  // Table memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[used_r[AW-1:0]] <= key;
    end
    rd_data <= mem[rd_addr];
  end

  // Line buffer bytes carry no reset.
  always_ff @(posedge clk) begin
    if (in_acc && !ended_r && (in_text_byte != 8'd0) &&
        (pos_r < PW'(LINE_BUFFER_BYTES))) begin
      line_r[pos_r[BW-1:0]] <= in_text_byte;
    end
  end

  // Sequencer, line counters, table fill count and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pos_r       <= '0;
      trim_r      <= '0;
      ovf_r       <= 1'b0;
      ended_r     <= 1'b0;
      used_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      res_status_r <= ST_NEW;
      res_slot_r  <= '0;
      out_status_r <= ST_NEW;
      out_index_r <= '0;
    end else begin
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      if (no_match) begin
        if (used_r < UW'(TABLE_ENTRIES)) begin
          res_status_r <= ST_NEW;
          res_slot_r   <= used_r;
          used_r       <= UW'(used_r + 1'b1);
        end else begin
          res_status_r <= ST_FULL;
          res_slot_r   <= '0;
        end
      end
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            if (!ended_r) begin
              if (in_text_byte == 8'd0) begin
                ended_r <= 1'b1;
              end else if (pos_r < PW'(LINE_BUFFER_BYTES)) begin
                pos_r <= PW'(pos_r + 1'b1);
                if (!is_blank(in_text_byte)) begin
                  trim_r <= PW'(pos_r + 1'b1);
                end
              end else begin
                ovf_r <= 1'b1;
              end
            end
            if (in_end_of_line) begin
              st_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          idx_r      <= '0;
          if (ovf_r) begin
            res_status_r <= ST_LENGTH;
            st_r <= S_DONE;
          end else if (trim_r == '0) begin
            res_status_r <= ST_BLANK;
            st_r <= S_DONE;
          end else if ((trim_r != PW'(LEN_ZULU)) && (trim_r != PW'(LEN_OFFSET))) begin
            res_status_r <= ST_LENGTH;
            st_r <= S_DONE;
          end else if (fmt_status != ST_NEW) begin
            res_status_r <= fmt_status;
            st_r <= S_DONE;
          end else if (used_r == '0) begin
            st_r <= S_DONE;
          end else begin
            st_r <= S_READ;
          end
        end
        S_READ: begin
          st_r <= S_CMP;
        end
        S_CMP: begin
          if (rd_data == key) begin
            res_status_r <= ST_DUP;
            res_slot_r   <= idx_r;
            st_r <= S_DONE;
          end else if (last_slot) begin
            st_r <= S_DONE;
          end else begin
            idx_r <= UW'(idx_r + 1'b1);
            st_r <= S_READ;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_index_r  <= (res_status_r == ST_NEW || res_status_r == ST_DUP) ?
                            8'(res_slot_r) : 8'd0;
            pos_r   <= '0;
            trim_r  <= '0;
            ovf_r   <= 1'b0;
            ended_r <= 1'b0;
            st_r    <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the table size.
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES))
    else $error("table fill count exceeds table size");

  // A table write always has a free slot.
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (used_r < UW'(TABLE_ENTRIES)))
    else $error("table write with no free slot");

  // Only new and duplicate words carry a slot number.
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_NEW) && (out_status_r != ST_DUP)) |->
      (out_index_r == 8'd0))
    else $error("nonzero slot on a rejected line");

  // A line end goes straight to the check.
  a_eol_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_end_of_line) |=> (st_r == S_CHECK))
    else $error("line end did not start the check");

endmodule

// ===== test/tb_top.sv =====
// Testbench for the timestamp checker: directed table of lines, then random lines, checked by a predictor.
module tb_top;
  import itvd_pkg::*;

  localparam int NUM_SLOTS = 256;
  localparam int BUF_BYTES = 32;
  localparam int LIMIT_CYCLES = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_text_byte;
  logic in_end_of_line;
  logic out_valid;
  logic out_ready;
  status_t out_status;
  logic [7:0] out_entry_index;

  iso8601_timestamp_validate_dedup_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_text_byte(in_text_byte), .in_end_of_line(in_end_of_line),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_entry_index(out_entry_index)
  );

  typedef struct packed {
    status_t    status;
    logic [7:0] index;
  } verdict_t;

  // Predictor state: the current line and the table of stored keys.
  logic [7:0] line_buf [BUF_BYTES];
  int         line_pos;
  int         trim_len;
  bit         line_long;
  bit         line_nul;
  key_t       stored_keys [NUM_SLOTS];
  int         keys_used;

  verdict_t verdicts_due [$];
  int  failures;
  int  cycle_count;
  int  sender_idle_pct;
  int  receiver_stall_pct;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic bit blank_ch(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // Two-character number under atoi rules.
  function automatic int num2(int p);
    logic [7:0] a;
    logic [7:0] b;
    a = line_buf[p];
    b = line_buf[p + 1];
    if (digit_ch(a)) return digit_ch(b) ? (a - "0") * 10 + (b - "0") : (a - "0");
    if (blank_ch(a) || a == "+") return digit_ch(b) ? (b - "0") : 0;
    if (a == "-") return digit_ch(b) ? -(b - "0") : 0;
    return 0;
  endfunction

  function automatic bit outside(int p, int lo, int hi);
    int v;
    v = num2(p);
    return v < lo || v > hi;
  endfunction

  function automatic status_t format_status(int len);
    if (len != LEN_ZULU && len != LEN_OFFSET) return ST_LENGTH;
    if (line_buf[4] != "-") return ST_STRUCT;
    if (outside(5, 1, 12)) return ST_MONTH;
    if (line_buf[7] != "-") return ST_STRUCT;
    if (outside(8, 1, 31)) return ST_DAY;
    if (line_buf[10] != "T") return ST_STRUCT;
    if (outside(11, 0, 23)) return ST_HOUR;
    if (line_buf[13] != ":") return ST_STRUCT;
    if (outside(14, 0, 59)) return ST_MINUTE;
    if (line_buf[16] != ":") return ST_STRUCT;
    if (outside(17, 0, 59)) return ST_SECOND;
    if (len == LEN_ZULU) return line_buf[19] == "Z" ? ST_NEW : ST_ZONE;
    if (line_buf[19] != "+" && line_buf[19] != "-") return ST_ZONE;
    if (outside(20, 0, 23)) return ST_ZHOUR;
    if (line_buf[22] != ":") return ST_STRUCT;
    if (outside(23, 0, 59)) return ST_ZMIN;
    return ST_NEW;
  endfunction

  // Advance the predictor by one accepted byte; returns 1 with a verdict at a line end.
  function automatic bit predict_byte(logic [7:0] c, logic eol, output verdict_t v);
    key_t k;
    int   hit;
    v = '0;
    if (!line_nul) begin
      if (c == 8'h00) line_nul = 1;
      else if (line_pos < BUF_BYTES) begin
        line_buf[line_pos] = c;
        line_pos++;
        if (!blank_ch(c)) trim_len = line_pos;
      end else line_long = 1;
    end
    if (!eol) return 0;
    if (line_long) v.status = ST_LENGTH;
    else if (trim_len == 0) v.status = ST_BLANK;
    else begin
      v.status = format_status(trim_len);
      if (v.status == ST_NEW) begin
        k = '0;
        for (int i = 0; i < trim_len; i++) k[i] = line_buf[i];
        hit = -1;
        for (int s = 0; s < keys_used; s++)
          if (hit < 0 && stored_keys[s] == k) hit = s;
        if (hit >= 0) begin
          v.status = ST_DUP;
          v.index = hit[7:0];
        end else if (keys_used >= NUM_SLOTS) v.status = ST_FULL;
        else begin
          stored_keys[keys_used] = k;
          v.index = keys_used[7:0];
          keys_used++;
        end
      end
    end
    line_pos = 0;
    trim_len = 0;
    line_long = 0;
    line_nul = 0;
    return 1;
  endfunction

  // Send one byte and, when it is accepted with a line end, queue the predicted verdict.
  task automatic send_byte(logic [7:0] c, logic eol);
    verdict_t v;
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= c;
    in_end_of_line <= eol;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (predict_byte(c, eol, v)) verdicts_due.push_back(v);
    @(negedge clk);
  endtask

  task automatic send_line(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Directed line with a typed-in verdict where it is obvious.
  task automatic send_checked(string s, bit has_want, status_t want);
    send_line(s);
    if (has_want && verdicts_due[$].status != want) begin
      $display("%0t directed line \"%s\": table expects %0d, predictor %0d",
               $time, s, want, verdicts_due[$].status);
      failures++;
    end
  endtask

  function automatic string two_digits(int v);
    return $sformatf("%0d%0d", v / 10, v % 10);
  endfunction

  // Random well-formed timestamp, Zulu or with an offset, in the years 2000 to 2002.
  function automatic string good_stamp();
    string s;
    s = $sformatf("20%s-%s-%sT%s:%s:%s", two_digits($urandom_range(0, 2)),
                  two_digits($urandom_range(1, 12)), two_digits($urandom_range(1, 31)),
                  two_digits($urandom_range(0, 23)), two_digits($urandom_range(0, 59)),
                  two_digits($urandom_range(0, 59)));
    if ($urandom_range(1)) return {s, "Z"};
    return {s, ($urandom_range(1) ? "+" : "-"), two_digits($urandom_range(0, 23)), ":",
            two_digits($urandom_range(0, 59))};
  endfunction

  // Random line: mostly good, some with a corrupted byte, some noise or padding.
  function automatic string random_line();
    string s;
    int n;
    int kind;
    kind = $urandom_range(99);
    s = good_stamp();
    if (kind < 45) begin
    end else if (kind < 80) begin
      s[$urandom_range(s.len() - 1)] = $urandom_range(1, 255);
    end else if (kind < 88) begin
      n = $urandom_range(1, 40);
      s = "";
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(0, 255)))};
      if (s.len() == 0) s = " ";
    end else if (kind < 94) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) s = {s, string'(8'($urandom_range(9, 13)))};
    end else begin
      s = {s, " "};
    end
    return s;
  endfunction

  // Result side: random stalls and comparison with the oldest expectation.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !(receiver_stall_pct > 0 && $urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected word: status %0d index %0d", $time, out_status,
                 out_entry_index);
        failures++;
      end else begin
        v = verdicts_due.pop_front();
        if (out_status !== v.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, v.status, out_status);
          failures++;
        end
        if (out_entry_index !== v.index) begin
          $display("%0t index mismatch: expected %0d actual %0d", $time, v.index,
                   out_entry_index);
          failures++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("iso8601_timestamp_validate_dedup_core test failed");
      $finish;
    end
  end

  initial begin
    string long_line;
    string probe;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_text_byte = 8'h00;
    in_end_of_line = 1'b0;
    out_ready = 1'b0;
    failures = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    line_pos = 0;
    trim_len = 0;
    line_long = 0;
    line_nul = 0;
    keys_used = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table: each status but table full, atoi corners, NUL ending, overlong lines.
    long_line = "";
    for (int i = 0; i < 33; i++) long_line = {long_line, " "};
    send_checked(" ", 1, ST_BLANK);
    send_checked(long_line, 1, ST_LENGTH);
    send_checked("2024-01-01T00:00:00Z", 1, ST_NEW);
    send_checked("2024-01-01T00:00:00Z\n", 1, ST_DUP);
    send_checked("9999-12-31T23:59:59+23:59", 1, ST_NEW);
    send_checked("2024-01-01T00:00:00-00:00", 1, ST_NEW);
    send_checked("2024-1", 1, ST_LENGTH);
    send_checked("2024/01-01T00:00:00Z", 1, ST_STRUCT);
    send_checked("2024-13-01T00:00:00Z", 1, ST_MONTH);
    send_checked("2024-00-01T00:00:00Z", 1, ST_MONTH);
    send_checked("2024-01-32T00:00:00Z", 1, ST_DAY);
    send_checked("2024-01-01T24:00:00Z", 1, ST_HOUR);
    send_checked("2024-01-01T00:60:00Z", 1, ST_MINUTE);
    send_checked("2024-01-01T00:00:60Z", 1, ST_SECOND);
    send_checked("2024-01-01T00:00:00Y", 1, ST_ZONE);
    send_checked("2024-01-01T00:00:00*01:00", 1, ST_ZONE);
    send_checked("2024-01-01T00:00:00+24:00", 1, ST_ZHOUR);
    send_checked("2024-01-01T00:00:00+01:60", 1, ST_ZMIN);
    send_checked("2024-01-01T00:00:00+01-00", 1, ST_STRUCT);
    send_checked("2024- 5-+3T-0:5x:ab+ 7:-0", 0, ST_NEW);
    send_checked("2024-01-01T00:-1:00Z", 1, ST_MINUTE);
    probe = "2024-02-02T02:02:02Z";
    for (int i = 0; i < probe.len(); i++) send_byte(probe[i], 1'b0);
    send_byte(8'h00, 1'b0);
    send_line("junk");
    send_checked({long_line, "2024"}, 1, ST_LENGTH);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random part in phases of idling.
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = (ph == 1 || ph == 3) ? 56 : 0;
      receiver_stall_pct = (ph == 2 || ph == 3) ? 56 : 0;
      if (ph == 3) begin
        sender_idle_pct = 6;
        receiver_stall_pct = 6;
      end
      for (int n = 0; n < 7; n++) send_line(random_line());
    end
    in_valid <= 1'b0;

    while (verdicts_due.size() != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    if (failures == 0) $display("iso8601_timestamp_validate_dedup_core test passed");
    else $display("iso8601_timestamp_validate_dedup_core test failed");
    $finish;
  end
endmodule
